// ===== sv/lru_page_order_tracker_unit_defines.svh =====
// assertion macros shared by the lru page order tracker rtl
// depends on a clock named clock and an active high reset named reset in the using module
`ifndef LRU_PAGE_ORDER_TRACKER_UNIT_DEFINES_SVH
`define LRU_PAGE_ORDER_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPOT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define LPOT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lpot_pkg.sv =====
// shared types and constants for the lru page order tracker
// no dependencies
`timescale 1ns / 1ps

package lpot_pkg;

   // width of the page fields on the ports
   localparam int PAGE_W = 6;

   // request command codes
   typedef enum logic [0:0] {
      CMD_TOUCH  = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

endpackage

// ===== sv/lpot_ram.sv =====
// generic single write port ram with registered read (old data on read during write)
// no dependencies
`timescale 1ns / 1ps

module lpot_ram #(
   parameter int  WIDTH = 6,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lru_page_order_tracker_unit.sv =====
// lru page order tracker top level: doubly linked lru list over per-page link rams
// depends on lpot_pkg, lpot_ram and lru_page_order_tracker_unit_defines.svh
`timescale 1ns / 1ps
`include "lru_page_order_tracker_unit_defines.svh"
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------------------
//   req      | in        | req_valid / req_stall        | req_command, req_page
//   rsp      | out       | rsp_valid / rsp_stall        | rsp_victim_page, rsp_victim_valid
//
// one word in per cycle while req_stall is low, one result word per request word
// link rams are read at accept; the op then runs from the input register into the result
// register that drives rsp_valid, with the previous op's link writes forwarded around the rams
// reset is synchronous; list membership and head/tail clear at once, link rams are not swept
// req_stall rises only while a word waits in the input register and the result register is
// held by rsp_stall

module lru_page_order_tracker_unit #(
   parameter int PAGE_COUNT = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [lpot_pkg::PAGE_W-1:0] req_page,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lpot_pkg::PAGE_W-1:0] rsp_victim_page,
   output logic                        rsp_victim_valid
);

   import lpot_pkg::*;

   localparam int IDX_W = $clog2(PAGE_COUNT);

   // handshake
   logic                  accept;
   logic                  exec;
   cmd_type               req_cmd;
   logic                  req_in_range;
   logic [IDX_W-1:0]      rd_addr;

   // input register
   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;
   logic                  s1_in_range_ff;
   logic [IDX_W-1:0]      s1_addr_ff;

   // list state
   logic [PAGE_COUNT-1:0] in_list_ff, in_list_in;
   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [IDX_W-1:0]      newest_ff, newest_in;
   logic                  list_empty_ff, list_empty_in;

   // which bank holds the latest next / prev link of each page
   logic [PAGE_COUNT-1:0] lvt_next_ff;
   logic [PAGE_COUNT-1:0] lvt_prev_ff;

   // link ram ports
   logic                  na_we, nb_we, pa_we, pb_we;
   logic [IDX_W-1:0]      na_wa, nb_wa, pa_wa, pb_wa;
   logic [IDX_W-1:0]      na_wd, nb_wd, pa_wd, pb_wd;
   logic [IDX_W-1:0]      na_q, nb_q, pa_q, pb_q;

   // last op's link writes, for forwarding
   logic                  fwd_na_en_ff, fwd_nb_en_ff, fwd_pa_en_ff, fwd_pb_en_ff;
   logic [IDX_W-1:0]      fwd_na_addr_ff, fwd_nb_addr_ff, fwd_pa_addr_ff, fwd_pb_addr_ff;
   logic [IDX_W-1:0]      fwd_na_data_ff, fwd_nb_data_ff, fwd_pa_data_ff, fwd_pb_data_ff;

   // resolved link reads for the word in the input register
   logic [IDX_W-1:0]      next_rd;
   logic [IDX_W-1:0]      prev_rd;

   // op results
   logic                  append;
   logic [PAGE_W-1:0]     victim_page;
   logic                  victim_valid;

   // result register
   logic                  rsp_valid_ff;
   logic [PAGE_W-1:0]     rsp_victim_page_ff;
   logic                  rsp_victim_valid_ff;

   // handshake and read address
   assign req_cmd      = cmd_type'(req_command);
   assign req_in_range = (int'(req_page) < PAGE_COUNT);
   assign exec         = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall    = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rd_addr      = (req_cmd == CMD_REMOVE) ? oldest_in :
                         (req_in_range ? IDX_W'(req_page) : '0);

   // next link banks
   lpot_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_next_a (
      .clock(clock), .wr_en(na_we), .wr_addr(na_wa), .wr_data(na_wd),
      .rd_en(accept), .rd_addr(rd_addr), .rd_data(na_q)
   );
   lpot_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_next_b (
      .clock(clock), .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_en(accept), .rd_addr(rd_addr), .rd_data(nb_q)
   );

   // prev link banks
   lpot_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_prev_a (
      .clock(clock), .wr_en(pa_we), .wr_addr(pa_wa), .wr_data(pa_wd),
      .rd_en(accept), .rd_addr(rd_addr), .rd_data(pa_q)
   );
   lpot_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_prev_b (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd),
      .rd_en(accept), .rd_addr(rd_addr), .rd_data(pb_q)
   );

   // pick the live bank, then forward the previous op's writes
   always_comb begin
      next_rd = lvt_next_ff[s1_addr_ff] ? nb_q : na_q;
      if (fwd_nb_en_ff && (fwd_nb_addr_ff == s1_addr_ff)) begin
         next_rd = fwd_nb_data_ff;
      end
      if (fwd_na_en_ff && (fwd_na_addr_ff == s1_addr_ff)) begin
         next_rd = fwd_na_data_ff;
      end
      prev_rd = lvt_prev_ff[s1_addr_ff] ? pb_q : pa_q;
      if (fwd_pb_en_ff && (fwd_pb_addr_ff == s1_addr_ff)) begin
         prev_rd = fwd_pb_data_ff;
      end
      if (fwd_pa_en_ff && (fwd_pa_addr_ff == s1_addr_ff)) begin
         prev_rd = fwd_pa_data_ff;
      end
   end

   // touch / remove on the list
   always_comb begin
      in_list_in    = in_list_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      list_empty_in = list_empty_ff;
      na_we = 1'b0; na_wa = '0; na_wd = '0;
      nb_we = 1'b0; nb_wa = '0; nb_wd = '0;
      pa_we = 1'b0; pa_wa = '0; pa_wd = '0;
      pb_we = 1'b0; pb_wa = '0; pb_wd = '0;
      append       = 1'b0;
      victim_page  = '0;
      victim_valid = 1'b0;
      if (exec) begin
         case (s1_cmd_ff)
            CMD_TOUCH: begin
               if (s1_in_range_ff) begin
                  if (in_list_ff[s1_addr_ff]) begin
                     // unlink a page already listed, unless it is the tail
                     if (s1_addr_ff != newest_ff) begin
                        if (s1_addr_ff == oldest_ff) begin
                           oldest_in = next_rd;
                        end else begin
                           na_we = 1'b1;
                           na_wa = prev_rd;
                           na_wd = next_rd;
                        end
                        pa_we  = 1'b1;
                        pa_wa  = next_rd;
                        pa_wd  = prev_rd;
                        append = 1'b1;
                     end
                  end else begin
                     in_list_in[s1_addr_ff] = 1'b1;
                     if (list_empty_ff) begin
                        oldest_in     = s1_addr_ff;
                        newest_in     = s1_addr_ff;
                        list_empty_in = 1'b0;
                     end else begin
                        append = 1'b1;
                     end
                  end
               end
            end
            CMD_REMOVE: begin
               // pop the head
               if (!list_empty_ff) begin
                  victim_page           = PAGE_W'(oldest_ff);
                  victim_valid          = 1'b1;
                  in_list_in[oldest_ff] = 1'b0;
                  if (oldest_ff == newest_ff) begin
                     list_empty_in = 1'b1;
                  end else begin
                     oldest_in = next_rd;
                  end
               end
            end
            default: begin
            end
         endcase
         // link the page in at the tail
         if (append) begin
            nb_we     = 1'b1;
            nb_wa     = newest_ff;
            nb_wd     = s1_addr_ff;
            pb_we     = 1'b1;
            pb_wa     = s1_addr_ff;
            pb_wd     = newest_ff;
            newest_in = s1_addr_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_list_ff    <= '0;
         oldest_ff     <= '0;
         newest_ff     <= '0;
         list_empty_ff <= 1'b1;
         fwd_na_en_ff  <= 1'b0;
         fwd_nb_en_ff  <= 1'b0;
         fwd_pa_en_ff  <= 1'b0;
         fwd_pb_en_ff  <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (exec) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         in_list_ff    <= in_list_in;
         oldest_ff     <= oldest_in;
         newest_ff     <= newest_in;
         list_empty_ff <= list_empty_in;
         if (exec) begin
            fwd_na_en_ff <= na_we;
            fwd_nb_en_ff <= nb_we;
            fwd_pa_en_ff <= pa_we;
            fwd_pb_en_ff <= pb_we;
         end
      end
   end

   // payload registers and bank select bits
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= req_cmd;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= rd_addr;
      end
      if (exec) begin
         rsp_victim_page_ff  <= victim_page;
         rsp_victim_valid_ff <= victim_valid;
         fwd_na_addr_ff      <= na_wa;
         fwd_na_data_ff      <= na_wd;
         fwd_nb_addr_ff      <= nb_wa;
         fwd_nb_data_ff      <= nb_wd;
         fwd_pa_addr_ff      <= pa_wa;
         fwd_pa_data_ff      <= pa_wd;
         fwd_pb_addr_ff      <= pb_wa;
         fwd_pb_data_ff      <= pb_wd;
         if (na_we) begin
            lvt_next_ff[na_wa] <= 1'b0;
         end
         if (nb_we) begin
            lvt_next_ff[nb_wa] <= 1'b1;
         end
         if (pa_we) begin
            lvt_prev_ff[pa_wa] <= 1'b0;
         end
         if (pb_we) begin
            lvt_prev_ff[pb_wa] <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_page  = rsp_victim_page_ff;
   assign rsp_victim_valid = rsp_victim_valid_ff;

   // checks
   `LPOT_ASSERT_IMP(a_empty_no_members, list_empty_ff, in_list_ff == '0, "empty list has members")
   `LPOT_ASSERT_IMP(a_ends_listed, !list_empty_ff, in_list_ff[oldest_ff] && in_list_ff[newest_ff], "list head or tail not marked as member")
   `LPOT_ASSERT_NXT(a_pop_reported, exec && (s1_cmd_ff == CMD_REMOVE) && !list_empty_ff, rsp_valid_ff && rsp_victim_valid_ff, "pop of a nonempty list not reported")
   `LPOT_ASSERT_NXT(a_no_false_victim, exec && ((s1_cmd_ff == CMD_TOUCH) || list_empty_ff), rsp_valid_ff && !rsp_victim_valid_ff, "victim reported without a pop")
   `LPOT_ASSERT_IMP(a_next_banks_apart, fwd_na_en_ff && fwd_nb_en_ff, fwd_na_addr_ff != fwd_nb_addr_ff, "both next link banks written at one page")

endmodule
